>>> rtl/metronome_click_generator_macros.svh
// assertion macros for the metronome click generator
// included by the top level, no other dependencies
`ifndef METRONOME_CLICK_GENERATOR_MACROS_SVH
`define METRONOME_CLICK_GENERATOR_MACROS_SVH

// property must hold at every clock edge outside reset
`define MCG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define MCG_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `MCG_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

>>> rtl/mcg_pkg.sv
// shared types, constants and the sine table builder of the metronome click generator
// no dependencies
package mcg_pkg;

  // default sizes
  localparam int unsigned SineTableBitsDef = 10;
  localparam int unsigned PosIntBitsDef    = 16;

  // field widths
  localparam int unsigned SampleW   = 24;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned ClickLenW = 13;
  localparam int unsigned EnvScaleW = 23;
  localparam int unsigned PhaseW    = 32;
  localparam int unsigned StepW     = 31;
  localparam int unsigned PeriodW   = 5;
  localparam int unsigned FracW     = 32;
  localparam int unsigned SineW     = 16;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;

  // shared multiplier operand widths
  localparam int unsigned MulAW = 25;
  localparam int unsigned MulBW = 23;
  localparam int unsigned MulPW = MulAW + MulBW;

  // register reset values
  localparam logic [FracW-1:0]     BeatStepRst     = 32'd178957;
  localparam logic [ClickLenW-1:0] ClickSamplesRst = 13'd1680;
  localparam logic [EnvScaleW-1:0] EnvScaleRst     = 23'd2497;
  localparam logic [StepW-1:0]     AccentStepRst   = 31'd118111601;
  localparam logic [StepW-1:0]     NormalStepRst   = 31'd78741067;
  localparam logic [PeriodW-1:0]   AccentPeriodRst = 5'd4;

  // gain and sample limits
  localparam logic [MulAW-1:0]   GainOne   = 25'h1000000;
  localparam logic [SampleW-1:0] SampleMax = 24'h7fffff;
  localparam logic [SampleW-1:0] SampleMin = 24'h800000;

  typedef enum logic [CmdW-1:0] {
    CMD_PLAY  = 2'd0,
    CMD_PAUSE = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_e;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_ENABLE        = 3'd0,
    CFG_BEAT_STEP     = 3'd1,
    CFG_CLICK_SAMPLES = 3'd2,
    CFG_ENV_SCALE     = 3'd3,
    CFG_ACCENT_STEP   = 3'd4,
    CFG_NORMAL_STEP   = 3'd5,
    CFG_ACCENT_PERIOD = 3'd6
  } cfg_idx_e;

  // quarter-wave sine entry, Q30 series, evaluated only while building the rom
  function automatic logic [SineW-1:0] sine_entry(int unsigned idx, int unsigned tbits);
    logic [63:0] q30_one;
    logic [63:0] u;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] v;
    q30_one = 64'd1 << 30;
    u    = 64'(2 * idx + 1) << (29 - tbits);
    t    = (u * 64'd1686629713) >> 30;
    t2   = (t * t) >> 30;
    term = q30_one - t2 / 64'd72;
    term = q30_one - ((t2 * term) >> 30) / 64'd42;
    term = q30_one - ((t2 * term) >> 30) / 64'd20;
    term = q30_one - ((t2 * term) >> 30) / 64'd6;
    s    = (t * term) >> 30;
    v    = (s * 64'd65535 + (64'd1 << 29)) >> 30;
    if (v > 64'd65535) begin
      v = 64'd65535;
    end
    return v[SineW-1:0];
  endfunction

endpackage

>>> rtl/mcg_mul.sv
// shared unsigned multiplier with registered product
// depends on mcg_pkg
module mcg_mul import mcg_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic [MulPW-1:0] p_o
);

  logic [MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MulPW'(a_i) * MulPW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/mcg_sine_rom.sv
// quarter-wave sine rom with registered read, contents built at elaboration
// depends on mcg_pkg
module mcg_sine_rom import mcg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS = SineTableBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [SINE_TABLE_BITS-1:0] addr_i,
  output logic [SineW-1:0]           data_o
);

  localparam int unsigned Depth = 1 << SINE_TABLE_BITS;

  typedef logic [SineW-1:0] rom_t [Depth];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < Depth; i++) begin
      r[i] = sine_entry(i, SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  logic [SineW-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_q <= SineRom[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

>>> rtl/metronome_click_generator.sv
// metronome click generator: beat tracking, sine burst and mix with the track
// depends on mcg_pkg, mcg_mul, mcg_sine_rom and metronome_click_generator_macros.svh
//
// usage
// - slave stream: one request per audio sample; tuser carries the command
//   (play, pause or stop; the unused code acts as pause), tdata the Q1.23 track sample
// - master stream: one result per request; tdata is the mixed Q1.23 sample,
//   tuser flags a click start and whether that click is accented
// - config port: write enable, register index, data; written while idle
// - a play request passes the beat, gain, magnitude, sum and hand-off states
//   before the next acceptance; the result is loaded into the output register at hand-off
// - the first play request after pause or stop, or after a write of the
//   accent period, also passes the remainder state: the beat number is
//   reduced modulo the accent period one bit per cycle, later beats update
//   that remainder incrementally
// - pause and stop requests go straight to hand-off and return a zero sample
// - one multiplier is shared: envelope gain first, then sine times gain
// - reset clears the beat position, the pending beat and the burst state,
//   and loads the register defaults; the sine rom needs no clearing
// - a stalled receiver holds the result in the output register; the
//   sequencer finishes the next request and waits for that register to free
`include "metronome_click_generator_macros.svh"

module metronome_click_generator import mcg_pkg::*; #(
  parameter int unsigned SINE_TABLE_BITS   = SineTableBitsDef,
  parameter int unsigned POSITION_INT_BITS = PosIntBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [SampleW-1:0]  s_axis_tdata,  // [23:0] track_sample
  input  logic [CmdW-1:0]     s_axis_tuser,  // [1:0] command
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [SampleW-1:0]  m_axis_tdata,  // [23:0] out_sample
  output logic [1:0]          m_axis_tuser,  // [0] click_start, [1] downbeat
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned PI   = POSITION_INT_BITS;
  localparam int unsigned PosW = PI + FracW;
  localparam int unsigned CntW = $clog2(PI);
  localparam int unsigned TB   = SINE_TABLE_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MOD  = 7'b0000010,
    S_BEAT = 7'b0000100,
    S_GAIN = 7'b0001000,
    S_MAG  = 7'b0010000,
    S_SUM  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  // configuration registers
  logic                 enable_q;
  logic [FracW-1:0]     beat_step_q;
  logic [ClickLenW-1:0] click_samples_q;
  logic [EnvScaleW-1:0] env_scale_q;
  logic [StepW-1:0]     accent_step_q;
  logic [StepW-1:0]     normal_step_q;
  logic [PeriodW-1:0]   accent_period_q;

  // sequencer and beat state
  state_e               state_q, state_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [PI-1:0]        nb_q, nb_d;
  logic                 was_playing_q, was_playing_d;
  logic [ClickLenW-1:0] rem_q, rem_d;
  logic [PhaseW-1:0]    phase_q, phase_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [PeriodW-1:0]   mod_q, mod_d;
  logic                 mod_valid_q, mod_valid_d;
  logic [CntW-1:0]      cnt_q, cnt_d;

  // per-request payload
  logic [SampleW-1:0]   track_q, track_d;
  logic                 sign_q, sign_d;
  logic                 start_q, start_d;
  logic                 accent_q, accent_d;
  logic [SampleW-1:0]   res_q, res_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [SampleW-1:0]   out_sample_q;
  logic                 out_start_q;
  logic                 out_down_q;
  logic                 out_load;

  // shared unit and rom
  logic                 mul_en;
  logic [MulAW-1:0]     mul_a;
  logic [MulBW-1:0]     mul_b;
  logic [MulPW-1:0]     mul_p;
  logic                 rom_en;
  logic [TB-1:0]        rom_addr;
  logic [SineW-1:0]     rom_data;

  // combinational helpers
  logic                 in_fire;
  logic [PI-1:0]        int_pos;
  logic [PI-1:0]        align_nb;
  logic [PI-1:0]        beat_diff;
  logic                 beat_reached;
  logic [PeriodW-1:0]   per_eff;
  logic [PeriodW:0]     mod_shift;
  logic [PeriodW:0]     mod_next;
  logic [PeriodW-1:0]   mod_inc;
  logic [35:0]          gain_raw;
  logic [MulAW-1:0]     gain;
  logic [40:0]          prod_round;
  logic [SampleW-1:0]   prod;
  logic [SampleW:0]     click;
  logic signed [25:0]   sum;
  logic [SampleW-1:0]   sum_sat;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // beat position: integer part and the ceiling used to realign
  assign int_pos   = pos_q[PosW-1:FracW];
  assign align_nb  = int_pos + PI'(|pos_q[FracW-1:0]);
  // beat reached, while enabled, when the position is at it or less than half a wrap past it
  assign beat_diff    = int_pos - nb_q;
  assign beat_reached = enable_q && !beat_diff[PI-1];

  // accent period zero behaves as one
  assign per_eff = (accent_period_q == '0) ? PeriodW'(1) : accent_period_q;

  // one restoring step of the beat-number remainder, msb first
  assign mod_shift = {mod_q, nb_q[cnt_q]};
  assign mod_next  = (mod_shift >= {1'b0, per_eff}) ? (mod_shift - {1'b0, per_eff})
                                                    : mod_shift;
  assign mod_inc   = mod_q + PeriodW'(1);

  // rom address: mirror in odd quadrants
  assign rom_addr = phase_q[30] ? ~phase_q[29 -: TB] : phase_q[29 -: TB];

  // envelope gain clamped to unity
  assign gain_raw = mul_p[35:0];
  assign gain     = (gain_raw > 36'(GainOne)) ? GainOne : gain_raw[MulAW-1:0];

  // rounded click magnitude, then sign and saturating mix
  assign prod_round = mul_p[40:0] + 41'(1 << 16);
  assign prod       = prod_round[40:17];
  assign click      = sign_q ? (~{1'b0, prod} + 25'd1) : {1'b0, prod};
  assign sum        = $signed({{2{track_q[SampleW-1]}}, track_q})
                    + ((rem_q != '0) ? $signed({click[SampleW], click}) : 26'sd0);

  always_comb begin
    if (sum > 26'sd8388607) begin
      sum_sat = SampleMax;
    end else if (sum < -26'sd8388608) begin
      sum_sat = SampleMin;
    end else begin
      sum_sat = sum[SampleW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    nb_d          = nb_q;
    was_playing_d = was_playing_q;
    rem_d         = rem_q;
    phase_d       = phase_q;
    step_d        = step_q;
    mod_d         = mod_q;
    mod_valid_d   = mod_valid_q;
    cnt_d         = cnt_q;
    track_d       = track_q;
    sign_d        = sign_q;
    start_d       = start_q;
    accent_d      = accent_q;
    res_d         = res_q;
    out_load      = 1'b0;
    mul_en        = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    rom_en        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          track_d = s_axis_tdata;
          if (s_axis_tuser == CMD_PLAY) begin
            was_playing_d = 1'b1;
            if (!was_playing_q) begin
              nb_d = align_nb;
            end
            if (!was_playing_q || !mod_valid_q) begin
              // fresh remainder of the pending beat number
              mod_d       = '0;
              mod_valid_d = 1'b0;
              cnt_d       = CntW'(PI - 1);
              state_d     = S_MOD;
            end else begin
              state_d = S_BEAT;
            end
          end else begin
            // pause, stop or unused code: zero result, burst held
            was_playing_d = 1'b0;
            if (s_axis_tuser == CMD_STOP) begin
              pos_d = '0;
            end
            res_d    = '0;
            start_d  = 1'b0;
            accent_d = 1'b0;
            state_d  = S_DONE;
          end
        end
      end
      S_MOD: begin
        mod_d = mod_next[PeriodW-1:0];
        if (cnt_q == '0) begin
          mod_valid_d = 1'b1;
          state_d     = S_BEAT;
        end else begin
          cnt_d = cnt_q - CntW'(1);
        end
      end
      S_BEAT: begin
        start_d  = 1'b0;
        accent_d = 1'b0;
        if (beat_reached) begin
          start_d  = 1'b1;
          accent_d = (mod_q == '0);
          step_d   = (mod_q == '0) ? accent_step_q : normal_step_q;
          rem_d    = click_samples_q;
          phase_d  = '0;
          nb_d     = nb_q + PI'(1);
          // keep the remainder in step with the beat number
          if (&nb_q || (mod_inc == per_eff)) begin
            mod_d = '0;
          end else begin
            mod_d = mod_inc;
          end
        end
        state_d = S_GAIN;
      end
      S_GAIN: begin
        mul_en  = 1'b1;
        mul_a   = MulAW'(rem_q);
        mul_b   = env_scale_q;
        rom_en  = 1'b1;
        sign_d  = phase_q[31];
        state_d = S_MAG;
      end
      S_MAG: begin
        mul_en  = 1'b1;
        mul_a   = gain;
        mul_b   = MulBW'(rom_data);
        state_d = S_SUM;
      end
      S_SUM: begin
        res_d = sum_sat;
        if (rem_q != '0) begin
          phase_d = phase_q + PhaseW'(step_q);
          rem_d   = rem_q - ClickLenW'(1);
        end
        pos_d   = pos_q + PosW'(beat_step_q);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a new accent period makes the remainder stale
    if (cfg_we_i && (cfg_addr_i == CFG_ACCENT_PERIOD)) begin
      mod_valid_d = 1'b0;
    end
  end

  assign out_valid_d = (out_valid_q && !m_axis_tready) || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pos_q         <= '0;
      nb_q          <= '0;
      was_playing_q <= 1'b0;
      rem_q         <= '0;
      phase_q       <= '0;
      step_q        <= '0;
      mod_q         <= '0;
      mod_valid_q   <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      pos_q         <= pos_d;
      nb_q          <= nb_d;
      was_playing_q <= was_playing_d;
      rem_q         <= rem_d;
      phase_q       <= phase_d;
      step_q        <= step_d;
      mod_q         <= mod_d;
      mod_valid_q   <= mod_valid_d;
      cnt_q         <= cnt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    track_q  <= track_d;
    sign_q   <= sign_d;
    start_q  <= start_d;
    accent_q <= accent_d;
    res_q    <= res_d;
    if (out_load) begin
      out_sample_q <= res_q;
      out_start_q  <= start_q;
      out_down_q   <= accent_q;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q        <= 1'b0;
      beat_step_q     <= BeatStepRst;
      click_samples_q <= ClickSamplesRst;
      env_scale_q     <= EnvScaleRst;
      accent_step_q   <= AccentStepRst;
      normal_step_q   <= NormalStepRst;
      accent_period_q <= AccentPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ENABLE:        enable_q        <= cfg_wdata_i[0];
        CFG_BEAT_STEP:     beat_step_q     <= cfg_wdata_i[FracW-1:0];
        CFG_CLICK_SAMPLES: click_samples_q <= cfg_wdata_i[ClickLenW-1:0];
        CFG_ENV_SCALE:     env_scale_q     <= cfg_wdata_i[EnvScaleW-1:0];
        CFG_ACCENT_STEP:   accent_step_q   <= cfg_wdata_i[StepW-1:0];
        CFG_NORMAL_STEP:   normal_step_q   <= cfg_wdata_i[StepW-1:0];
        CFG_ACCENT_PERIOD: accent_period_q <= cfg_wdata_i[PeriodW-1:0];
        default: begin
        end
      endcase
    end
  end

  mcg_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mcg_sine_rom #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_sine_rom (
    .clk_i   (clk_i),
    .rd_en_i (rom_en),
    .addr_i  (rom_addr),
    .data_o  (rom_data)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = {out_down_q, out_start_q};

  // an accented result always marks a click start
  `MCG_ASSERT(a_down_has_start, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0], "downbeat without click start")

  // a valid remainder stays below the effective accent period
  `MCG_ASSERT(a_mod_range, clk_i, rst_ni, mod_valid_q |-> (mod_q < per_eff), "beat remainder out of range")

  // pause or stop goes straight to hand-off with a silent sample
  `MCG_ASSERT(a_idle_cmd_silent, clk_i, rst_ni, in_fire && (s_axis_tuser != CMD_PLAY) |=> (state_q == S_DONE) && (res_q == '0) && !start_q, "non-play request not silenced")

  // the shared multiplier is never driven while the remainder is computed
  `MCG_ASSERT_NEVER(a_mul_idle_in_mod, clk_i, rst_ni, (state_q == S_MOD) && mul_en, "multiplier used during remainder pass")

endmodule

>>> verif/metronome_click_generator_tb.sv
// self-checking testbench for the metronome click generator: a cycle-free predictor of
// beat tracking, sine burst and saturating mix checks every result against the block
// depends on mcg_pkg and the rtl of metronome_click_generator
module metronome_click_generator_tb;
  import mcg_pkg::*;

  localparam int unsigned TblBits   = SineTableBitsDef;
  localparam int unsigned PosBits   = PosIntBitsDef;
  localparam int unsigned TblSize   = 1 << TblBits;
  localparam int unsigned ClkHalf   = 5;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned SprintItems = 64;
  localparam int          MixMax    = (1 << (SampleW - 1)) - 1;
  localparam int          MixMin    = -(1 << (SampleW - 1));
  // command code outside the enum, behaves as pause
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [SampleW-1:0]  s_axis_tdata;   // [23:0] track_sample
  logic [CmdW-1:0]     s_axis_tuser;   // [1:0] command
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SampleW-1:0]  m_axis_tdata;   // [23:0] out_sample
  logic [1:0]          m_axis_tuser;   // [0] click_start, [1] downbeat
  logic                cfg_we_i;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  metronome_click_generator #(
    .SINE_TABLE_BITS  (TblBits),
    .POSITION_INT_BITS(PosBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               click;
    logic               accent;
  } mix_t;

  // mirrors the block: register copies, beat and burst state, queue of mixes still owed
  class click_mix_board;
    bit                   en;
    logic [FracW-1:0]     step;
    logic [ClickLenW-1:0] clen;
    logic [EnvScaleW-1:0] escale;
    logic [StepW-1:0]     astep;
    logic [StepW-1:0]     nstep;
    logic [PeriodW-1:0]   aper;

    logic [PosBits+FracW-1:0] pos;
    logic [PosBits-1:0]       nbeat;
    bit                       playing;
    logic [ClickLenW-1:0]     remain;
    logic [PhaseW-1:0]        phase;
    logic [PhaseW-1:0]        pstep;
    logic [SineW-1:0]         sine_rom [TblSize];

    mix_t pending_mixes[$];
    int unsigned errors, requests, results, clicks, accents;

    function new();
      en = 1'b0;
      step = BeatStepRst;
      clen = ClickSamplesRst;
      escale = EnvScaleRst;
      astep = AccentStepRst;
      nstep = NormalStepRst;
      aper = AccentPeriodRst;
      pos = '0;
      nbeat = '0;
      playing = 1'b0;
      remain = '0;
      phase = '0;
      pstep = '0;
      for (int i = 0; i < TblSize; i++) sine_rom[i] = quarter_sine(i);
    endfunction

    // quarter-wave entry at the middle of bin i, Q30 taylor series
    function logic [SineW-1:0] quarter_sine(int unsigned i);
      longint unsigned one, x, x2, acc, s, v;
      one = 64'd1 << 30;
      x   = ((64'(2 * i + 1) << (29 - TblBits)) * 64'd1686629713) >> 30;
      x2  = (x * x) >> 30;
      acc = one - x2 / 72;
      acc = one - ((x2 * acc) >> 30) / 42;
      acc = one - ((x2 * acc) >> 30) / 20;
      acc = one - ((x2 * acc) >> 30) / 6;
      s   = (x * acc) >> 30;
      v   = (s * 65535 + (64'd1 << 29)) >> 30;
      if (v > 65535) v = 65535;
      return v[SineW-1:0];
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_ENABLE:        en = val[0];
        CFG_BEAT_STEP:     step = val;
        CFG_CLICK_SAMPLES: clen = val[ClickLenW-1:0];
        CFG_ENV_SCALE:     escale = val[EnvScaleW-1:0];
        CFG_ACCENT_STEP:   astep = val[StepW-1:0];
        CFG_NORMAL_STEP:   nstep = val[StepW-1:0];
        CFG_ACCENT_PERIOD: aper = val[PeriodW-1:0];
        default: ;
      endcase
    endfunction

    // signed burst value at the current phase and envelope
    function int burst_level();
      logic [1:0]                     quad;
      logic [TblBits-1:0]             idx;
      logic [ClickLenW+EnvScaleW-1:0] gain;
      longint unsigned                prod;
      quad = phase[PhaseW-1 -: 2];
      idx  = phase[PhaseW-3 -: TblBits];
      if (quad[0]) idx = ~idx;  // mirrored quadrant
      gain = remain * escale;
      if (gain > (1 << 24)) gain = 1 << 24;  // unity gain ceiling
      prod = (64'(sine_rom[idx]) * 64'(gain) + 64'd65536) >> 17;
      return quad[1] ? -int'(prod) : int'(prod);
    endfunction

    function void take_sample_request(logic [CmdW-1:0] cmd, logic [SampleW-1:0] track);
      mix_t               r;
      int                 sum;
      logic [PosBits-1:0] ip;
      logic [PosBits-1:0] lead;
      int unsigned        per;
      r = '0;
      requests++;
      if (cmd != CMD_PLAY) begin
        // pause, stop and the unused code: silent, burst held
        playing = 1'b0;
        if (cmd == CMD_STOP) pos = '0;
        pending_mixes.push_back(r);
        return;
      end
      ip = pos[FracW +: PosBits];
      if (!playing) begin
        // resume: next beat is the ceiling of the position
        nbeat = ip + (pos[FracW-1:0] != '0);
        playing = 1'b1;
      end
      if (en) begin
        lead = ip - nbeat;
        if (!lead[PosBits-1]) begin
          per = (aper == '0) ? 1 : aper;
          r.accent = (nbeat % per) == 0;
          r.click = 1'b1;
          pstep = r.accent ? {1'b0, astep} : {1'b0, nstep};
          remain = clen;
          phase = '0;
          nbeat = nbeat + 1'b1;
          clicks++;
          if (r.accent) accents++;
        end
      end
      sum = $signed(track);
      if (remain != '0) begin
        sum += burst_level();
        phase = phase + pstep;
        remain = remain - 1'b1;
      end
      if (sum > MixMax) sum = MixMax;
      if (sum < MixMin) sum = MixMin;
      pos = pos + step;
      r.sample = sum[SampleW-1:0];
      pending_mixes.push_back(r);
    endfunction

    function void check_mix_result(logic [SampleW-1:0] sample, logic [1:0] flags);
      mix_t r;
      results++;
      if (pending_mixes.size() == 0) begin
        $error("result with no request outstanding: out_sample %0d", $signed(sample));
        errors++;
        return;
      end
      r = pending_mixes.pop_front();
      if (sample !== r.sample) begin
        $error("out_sample: expected %0d, actual %0d", $signed(r.sample), $signed(sample));
        errors++;
      end
      if (flags[0] !== r.click) begin
        $error("click_start: expected %0b, actual %0b", r.click, flags[0]);
        errors++;
      end
      if (flags[1] !== r.accent) begin
        $error("downbeat: expected %0b, actual %0b", r.accent, flags[1]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_mixes.size();
    endfunction
  endclass

  click_mix_board board;
  bit             steady;       // no idling on either side while set
  int unsigned    sent_items;
  int unsigned    idle_cycles = 0;

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SampleW-1:0] pick_track();
    case ($urandom_range(0, 9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hffffff;
      default: return SampleW'($urandom());
    endcase
  endfunction

  function automatic logic [CmdW-1:0] pick_break();
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r < 3) return CMD_PAUSE;
    if (r < 5) return CMD_STOP;
    return CmdUnused;
  endfunction

  // one sample request; valid stays up when the next one follows without a gap
  task automatic send_sample(logic [CmdW-1:0] cmd, logic [SampleW-1:0] track);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= track;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.take_sample_request(cmd, track);
    sent_items++;
  endtask

  task automatic send_plays(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_sample(CMD_PLAY, pick_track());
  endtask

  // caller lowers the write enable after its last write
  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  // drain all owed results, then let the pipeline go quiet
  task automatic drain(int unsigned tail);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic program_regs(int unsigned ph);
    logic [CfgDataW-1:0] v;
    if (ph == 0) begin
      // all registers at or near their low end
      write_reg(CFG_ENABLE, 0);
      write_reg(CFG_BEAT_STEP, 0);
      write_reg(CFG_CLICK_SAMPLES, 1);
      write_reg(CFG_ENV_SCALE, 0);
      write_reg(CFG_ACCENT_STEP, 0);
      write_reg(CFG_NORMAL_STEP, 0);
      write_reg(CFG_ACCENT_PERIOD, 1);
    end else if (ph == 1) begin
      // all registers at the high end of the ranges the bench draws from
      write_reg(CFG_ENABLE, 1);
      write_reg(CFG_BEAT_STEP, 32'hffff_ffff);
      write_reg(CFG_CLICK_SAMPLES, 8191);
      write_reg(CFG_ENV_SCALE, 4194304);
      write_reg(CFG_ACCENT_STEP, 32'h7fff_ffff);
      write_reg(CFG_NORMAL_STEP, 32'h7fff_ffff);
      write_reg(CFG_ACCENT_PERIOD, 16);
    end else begin
      write_reg(CFG_ENABLE, CfgDataW'($urandom_range(0, 4) != 0));
      v = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(32'h0400_0000, 32'h6000_0000);
      write_reg(CFG_BEAT_STEP, v);
      v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 40);
      write_reg(CFG_CLICK_SAMPLES, v);
      write_reg(CFG_ENV_SCALE, $urandom_range(0, 4194304));
      write_reg(CFG_ACCENT_STEP, $urandom() & 32'h7fff_ffff);
      write_reg(CFG_NORMAL_STEP, $urandom() & 32'h7fff_ffff);
      write_reg(CFG_ACCENT_PERIOD, $urandom_range(0, 16));
    end
    cfg_we_i <= 1'b0;
  endtask

  // receiver: random stalls, held ready in steady stretches
  initial begin
    int unsigned n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_mix_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // watchdog: ends the run when no handshake or write happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no activity for %0d cycles", IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned n;
    bit          pressed;
    board = new();
    steady = 1'b0;
    sent_items = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_PLAY;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_ENABLE;
    cfg_wdata_i   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // beats every 4 samples, every beat accented (period zero), a quarter gain per burst sample left,
    // saturation at both rails, pause realign, stop, unused code
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_BEAT_STEP, 32'h4000_0000);
    write_reg(CFG_CLICK_SAMPLES, 3);
    write_reg(CFG_ENV_SCALE, 4194304);
    write_reg(CFG_ACCENT_STEP, 32'h7fff_ffff);
    write_reg(CFG_NORMAL_STEP, 32'h1000_0000);
    write_reg(CFG_ACCENT_PERIOD, 0);
    cfg_we_i <= 1'b0;
    send_sample(CMD_PLAY, 24'h7fffff);
    send_sample(CMD_PLAY, 24'h800000);
    send_sample(CMD_PLAY, 24'h000000);
    send_sample(CMD_PLAY, 24'hffffff);
    send_sample(CMD_PAUSE, 24'h555555);
    send_sample(CMD_PLAY, 24'haaaaaa);
    send_sample(CMD_STOP, 24'h7fffff);
    send_sample(CmdUnused, 24'h800000);
    send_plays(3);
    drain(8);

    // zero click length: flags only, no burst
    write_reg(CFG_CLICK_SAMPLES, 0);
    write_reg(CFG_ACCENT_PERIOD, 3);
    write_reg(CFG_BEAT_STEP, 32'hffff_ffff);
    cfg_we_i <= 1'b0;
    send_plays(4);
    drain(8);

    // enabled late: position runs ahead, then one click per sample to catch up
    write_reg(CFG_ENABLE, 0);
    write_reg(CFG_BEAT_STEP, 32'h8000_0000);
    write_reg(CFG_CLICK_SAMPLES, 5);
    write_reg(CFG_ENV_SCALE, 2497);
    cfg_we_i <= 1'b0;
    send_plays(6);
    drain(8);
    write_reg(CFG_ENABLE, 1);
    cfg_we_i <= 1'b0;
    send_plays(5);
    drain(8);

    // a run at almost one beat per sample, a click nearly every sample;
    // the pause then realigns the next beat to the ceiling of the position
    steady = 1'b1;
    send_sample(CMD_STOP, pick_track());
    drain(8);
    write_reg(CFG_BEAT_STEP, 32'hffff_ffff);
    write_reg(CFG_CLICK_SAMPLES, 2);
    write_reg(CFG_ACCENT_PERIOD, 16);
    cfg_we_i <= 1'b0;
    send_plays(SprintItems);
    send_sample(CMD_PAUSE, pick_track());
    send_plays(6);
    drain(8);
    steady = 1'b0;

    // random phases: play runs broken by pause, stop or the unused code,
    // some noise runs, a held-off sender once per phase
    for (int unsigned ph = 0; ph < 8; ph++) begin
      program_regs(ph);
      steady = (ph == 3) || (ph == 6);
      pressed = 1'b0;
      n = sent_items + PhaseItems;
      while (sent_items < n) begin
        if ($urandom_range(0, 11) == 0) begin
          repeat ($urandom_range(1, 10)) send_sample(CmdW'($urandom_range(0, 3)), pick_track());
        end else begin
          send_plays($urandom_range(1, 60));
          repeat ($urandom_range(1, 3)) send_sample(pick_break(), pick_track());
        end
        if (!pressed && sent_items + PhaseItems / 2 >= n) begin
          // sender holds off until the block has delivered everything
          pressed = 1'b1;
          s_axis_tvalid <= 1'b0;
          while (board.pending() != 0) @(posedge clk_i);
        end
      end
      drain(8);
    end
    steady = 1'b0;
    drain(20);

    $display("run covered %0d sample requests and %0d results",
             board.requests, board.results);
    $display("directed cases plus 8 register phases, clicks started: %0d, accented: %0d",
             board.clicks, board.accents);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/mcg_pkg.sv
rtl/mcg_mul.sv
rtl/mcg_sine_rom.sv
rtl/metronome_click_generator.sv
verif/metronome_click_generator_tb.sv
